>>> rtl/ncp_pkg.sv
package ncp_pkg;

	localparam int NUM_TIMERS  = 16;   // power of two: edge index is {parent, child}
	localparam int STACK_DEPTH = 32;
	localparam int TIME_BITS   = 48;
	localparam int COUNT_BITS  = 32;
	localparam int TOTAL_BITS  = 64;

	localparam int ID_BITS   = $clog2(NUM_TIMERS);
	localparam int PAIRS     = NUM_TIMERS * NUM_TIMERS;
	localparam int PAIR_BITS = 2 * ID_BITS;
	localparam int STK_BITS  = $clog2(STACK_DEPTH);
	localparam int LVL_BITS  = $clog2(STACK_DEPTH + 1);

	localparam logic KIND_START = 1'b0;
	localparam logic KIND_STOP  = 1'b1;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_EMPTY    = 2'd2,
		ST_MISMATCH = 2'd3
	} status_t;

	typedef struct packed {
		logic [ID_BITS-1:0]   id;
		logic [TIME_BITS-1:0] start;
	} stack_entry_t;

	typedef struct packed {
		logic [COUNT_BITS-1:0] starts;
		logic [COUNT_BITS-1:0] stops;
		logic [TOTAL_BITS-1:0] total;
	} pair_entry_t;

	typedef struct packed {
		logic                rd;
		logic                wr;
		logic [STK_BITS-1:0] addr;
	} stack_req_t;

	typedef struct packed {
		logic                 rd;
		logic                 wr;
		logic [PAIR_BITS-1:0] addr;
	} pair_req_t;

endpackage

>>> rtl/ncp_in_if.sv
interface ncp_in_if;
	logic                          valid;
	logic                          ready;
	logic                          kind;
	logic [3:0]                    timer_id;
	logic [ncp_pkg::TIME_BITS-1:0] timestamp;

	modport source (output valid, kind, timer_id, timestamp, input ready);
	modport sink   (input valid, kind, timer_id, timestamp, output ready);
endinterface

>>> rtl/ncp_out_if.sv
interface ncp_out_if;
	logic                           valid;
	logic                           ready;
	logic [1:0]                     status;
	logic [3:0]                     echo_id;
	logic [ncp_pkg::COUNT_BITS-1:0] timer_calls;
	logic [ncp_pkg::TOTAL_BITS-1:0] timer_total;
	logic [ncp_pkg::TIME_BITS-1:0]  elapsed;
	logic                           edge_valid;
	logic [ncp_pkg::COUNT_BITS-1:0] edge_calls;
	logic [ncp_pkg::TOTAL_BITS-1:0] edge_total;
	logic [ncp_pkg::LVL_BITS-1:0]   stack_level;

	modport source (output valid, status, echo_id, timer_calls, timer_total, elapsed,
		edge_valid, edge_calls, edge_total, stack_level, input ready);
	modport sink   (input valid, status, echo_id, timer_calls, timer_total, elapsed,
		edge_valid, edge_calls, edge_total, stack_level, output ready);
endinterface

>>> rtl/ncp_alu.sv
module ncp_alu (
	input  logic [ncp_pkg::TOTAL_BITS-1:0] a,
	input  logic [ncp_pkg::TOTAL_BITS-1:0] b,
	input  logic                           sub,
	output logic [ncp_pkg::TOTAL_BITS-1:0] sum
);
	import ncp_pkg::*;

	// subtract as a + ~b + 1
	assign sum = a + (sub ? ~b : b) + TOTAL_BITS'(sub);

endmodule

>>> rtl/ncp_stack.sv
module ncp_stack (
	input  logic                  clk,
	input  ncp_pkg::stack_req_t   req,
	input  ncp_pkg::stack_entry_t wr_data,
	output ncp_pkg::stack_entry_t rd_data
);
	import ncp_pkg::*;

	stack_entry_t mem [STACK_DEPTH];
	stack_entry_t rd_q;

	always_ff @(posedge clk) begin
		if (req.wr) begin
			mem[req.addr] <= wr_data;
		end
		if (req.rd) begin
			rd_q <= mem[req.addr];
		end
	end

	assign rd_data = rd_q;

endmodule

>>> rtl/ncp_pair_ram.sv
module ncp_pair_ram (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ncp_pkg::pair_req_t   req,
	input  ncp_pkg::pair_entry_t wr_data,
	output ncp_pkg::pair_entry_t rd_data
);
	import ncp_pkg::*;

	pair_entry_t      mem [PAIRS];
	pair_entry_t      rd_q;
	logic [PAIRS-1:0] written_q;
	logic             rd_written_q;

	// entries never written read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q    <= '0;
			rd_written_q <= 1'b0;
		end else begin
			if (req.wr) begin
				written_q[req.addr] <= 1'b1;
			end
			if (req.rd) begin
				rd_written_q <= written_q[req.addr];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.wr) begin
			mem[req.addr] <= wr_data;
		end
		if (req.rd) begin
			rd_q <= mem[req.addr];
		end
	end

	assign rd_data = rd_written_q ? rd_q : '0;

endmodule

>>> rtl/nested_call_profiler.sv
// Call-graph profiler for nested timers. Each input word is a start or stop of a timer
// with a timestamp; each yields one result word with the timer's and its parent edge's
// call count and total time. A start under a parent, and any stop, first reads the top of
// the stack; a stop under a parent then reads the parent's stack entry and the edge table.
// A full-stack or empty-stack word goes straight to the result, and a stop not on top
// ends once the top is read. All updates go one at a time through a single 64-bit adder,
// and the stack and the 256-entry edge table are single-port memories with registered
// reads. Edge table entries read as zero until first written, so no clearing pass is
// needed after reset. Input ready is high only while no word is in progress.
module nested_call_profiler (
	input logic      clk,
	input logic      arst_n,
	ncp_in_if.sink   in_ch,
	ncp_out_if.source out_ch
);
	import ncp_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_TOP, S_PAR, S_ELAP, S_OWN, S_OWN_TOT,
		S_PAIR, S_PAIR_TOT, S_PAIR_WR, S_DONE
	} state_t;

	state_t                state_q;
	logic                  kind_q;
	logic [ID_BITS-1:0]    id_q;
	logic [TIME_BITS-1:0]  now_q;
	logic [TIME_BITS-1:0]  start_q;
	logic [TIME_BITS-1:0]  elapsed_q;
	logic [ID_BITS-1:0]    parent_q;
	logic                  edge_q;
	status_t               status_q;
	pair_entry_t           pw_q;
	logic [LVL_BITS-1:0]   count_q;

	logic [COUNT_BITS-1:0] own_start_q [NUM_TIMERS];
	logic [COUNT_BITS-1:0] own_stop_q  [NUM_TIMERS];
	logic [TOTAL_BITS-1:0] own_total_q [NUM_TIMERS];

	logic                  out_valid_q;
	logic [1:0]            out_status_q;
	logic [3:0]            out_id_q;
	logic [COUNT_BITS-1:0] out_tcalls_q;
	logic [TOTAL_BITS-1:0] out_ttotal_q;
	logic [TIME_BITS-1:0]  out_elapsed_q;
	logic                  out_edge_q;
	logic [COUNT_BITS-1:0] out_ecalls_q;
	logic [TOTAL_BITS-1:0] out_etotal_q;
	logic [LVL_BITS-1:0]   out_level_q;

	logic                  in_fire;
	logic                  out_free;
	logic [LVL_BITS-1:0]   cnt_m1;
	logic [LVL_BITS-1:0]   cnt_m2;
	logic [LVL_BITS-1:0]   cnt_next;
	logic [ID_BITS-1:0]    in_id;

	stack_req_t            stk_req;
	stack_entry_t          stk_wdata;
	stack_entry_t          stk_rd;
	pair_req_t             pair_req;
	pair_entry_t           pair_rd;

	logic [TOTAL_BITS-1:0] alu_a;
	logic [TOTAL_BITS-1:0] alu_b;
	logic                  alu_sub;
	logic [TOTAL_BITS-1:0] alu_sum;

	assign in_fire  = in_ch.valid && in_ch.ready;
	assign out_free = !out_valid_q || out_ch.ready;
	assign cnt_m1   = count_q - LVL_BITS'(1);
	assign cnt_m2   = count_q - LVL_BITS'(2);
	assign in_id    = in_ch.timer_id[ID_BITS-1:0];

	always_comb begin
		if (status_q != ST_OK) begin
			cnt_next = count_q;
		end else if (kind_q == KIND_START) begin
			cnt_next = count_q + LVL_BITS'(1);
		end else begin
			cnt_next = cnt_m1;
		end
	end

	// stack port
	always_comb begin
		stk_req   = '0;
		stk_wdata = '{id: id_q, start: now_q};
		unique case (state_q)
			S_IDLE: begin
				stk_req.rd   = in_fire && count_q != '0 &&
					!(in_ch.kind == KIND_START && count_q == LVL_BITS'(STACK_DEPTH));
				stk_req.addr = cnt_m1[STK_BITS-1:0];
			end
			S_TOP: begin
				stk_req.rd   = kind_q == KIND_STOP && stk_rd.id == id_q &&
					count_q > LVL_BITS'(1);
				stk_req.addr = cnt_m2[STK_BITS-1:0];
			end
			S_DONE: begin
				stk_req.wr   = out_free && status_q == ST_OK && kind_q == KIND_START;
				stk_req.addr = count_q[STK_BITS-1:0];
			end
			default: ;
		endcase
	end

	// edge table port
	always_comb begin
		pair_req      = '0;
		pair_req.addr = {parent_q, id_q};
		unique case (state_q)
			S_TOP: begin
				pair_req.rd   = kind_q == KIND_START;
				pair_req.addr = {stk_rd.id, id_q};
			end
			S_PAR: begin
				pair_req.rd   = 1'b1;
				pair_req.addr = {stk_rd.id, id_q};
			end
			S_PAIR_WR: pair_req.wr = 1'b1;
			default: ;
		endcase
	end

	// operand selection for the shared adder
	always_comb begin
		alu_a   = '0;
		alu_b   = TOTAL_BITS'(1);
		alu_sub = 1'b0;
		unique case (state_q)
			S_ELAP: begin
				alu_a   = TOTAL_BITS'(now_q);
				alu_b   = TOTAL_BITS'(start_q);
				alu_sub = 1'b1;
			end
			S_OWN: begin
				alu_a = TOTAL_BITS'(kind_q == KIND_STOP ? own_stop_q[id_q] : own_start_q[id_q]);
			end
			S_OWN_TOT: begin
				alu_a = own_total_q[id_q];
				alu_b = TOTAL_BITS'(elapsed_q);
			end
			S_PAIR: begin
				alu_a = TOTAL_BITS'(kind_q == KIND_STOP ? pair_rd.stops : pair_rd.starts);
			end
			S_PAIR_TOT: begin
				alu_a = pw_q.total;
				alu_b = TOTAL_BITS'(elapsed_q);
			end
			default: ;
		endcase
	end

	ncp_alu u_alu (.a(alu_a), .b(alu_b), .sub(alu_sub), .sum(alu_sum));

	ncp_stack u_stack (.clk(clk), .req(stk_req), .wr_data(stk_wdata), .rd_data(stk_rd));

	ncp_pair_ram u_pair (
		.clk(clk), .arst_n(arst_n), .req(pair_req), .wr_data(pw_q), .rd_data(pair_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			kind_q        <= KIND_START;
			id_q          <= '0;
			now_q         <= '0;
			start_q       <= '0;
			elapsed_q     <= '0;
			parent_q      <= '0;
			edge_q        <= 1'b0;
			status_q      <= ST_OK;
			pw_q          <= '0;
			count_q       <= '0;
			for (int i = 0; i < NUM_TIMERS; i++) begin
				own_start_q[i] <= '0;
				own_stop_q[i]  <= '0;
				own_total_q[i] <= '0;
			end
			out_valid_q   <= 1'b0;
			out_status_q  <= '0;
			out_id_q      <= '0;
			out_tcalls_q  <= '0;
			out_ttotal_q  <= '0;
			out_elapsed_q <= '0;
			out_edge_q    <= 1'b0;
			out_ecalls_q  <= '0;
			out_etotal_q  <= '0;
			out_level_q   <= '0;
		end else begin
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						kind_q    <= in_ch.kind;
						id_q      <= in_id;
						now_q     <= in_ch.timestamp;
						elapsed_q <= '0;
						edge_q    <= 1'b0;
						status_q  <= ST_OK;
						if (in_ch.kind == KIND_START) begin
							if (count_q == LVL_BITS'(STACK_DEPTH)) begin
								status_q <= ST_FULL;
								state_q  <= S_DONE;
							end else if (count_q == '0) begin
								state_q <= S_OWN;
							end else begin
								state_q <= S_TOP;
							end
						end else if (count_q == '0) begin
							status_q <= ST_EMPTY;
							state_q  <= S_DONE;
						end else begin
							state_q <= S_TOP;
						end
					end
				end
				S_TOP: begin
					start_q <= stk_rd.start;
					if (kind_q == KIND_START) begin
						parent_q <= stk_rd.id;
						edge_q   <= 1'b1;
						state_q  <= S_OWN;
					end else if (stk_rd.id != id_q) begin
						status_q <= ST_MISMATCH;
						state_q  <= S_DONE;
					end else if (count_q > LVL_BITS'(1)) begin
						state_q <= S_PAR;
					end else begin
						state_q <= S_ELAP;
					end
				end
				S_PAR: begin
					parent_q <= stk_rd.id;
					edge_q   <= 1'b1;
					state_q  <= S_ELAP;
				end
				S_ELAP: begin
					elapsed_q <= alu_sum[TIME_BITS-1:0];
					state_q   <= S_OWN;
				end
				S_OWN: begin
					if (kind_q == KIND_START) begin
						own_start_q[id_q] <= alu_sum[COUNT_BITS-1:0];
						state_q           <= edge_q ? S_PAIR : S_DONE;
					end else begin
						own_stop_q[id_q] <= alu_sum[COUNT_BITS-1:0];
						state_q          <= S_OWN_TOT;
					end
				end
				S_OWN_TOT: begin
					// outermost return only: recursion is timed once
					if (own_stop_q[id_q] == own_start_q[id_q]) begin
						own_total_q[id_q] <= alu_sum;
					end
					state_q <= edge_q ? S_PAIR : S_DONE;
				end
				S_PAIR: begin
					if (kind_q == KIND_START) begin
						pw_q    <= '{starts: alu_sum[COUNT_BITS-1:0],
							stops: pair_rd.stops, total: pair_rd.total};
						state_q <= S_PAIR_WR;
					end else begin
						pw_q    <= '{starts: pair_rd.starts,
							stops: alu_sum[COUNT_BITS-1:0], total: pair_rd.total};
						state_q <= S_PAIR_TOT;
					end
				end
				S_PAIR_TOT: begin
					if (pw_q.stops == pw_q.starts) begin
						pw_q.total <= alu_sum;
					end
					state_q <= S_PAIR_WR;
				end
				S_PAIR_WR: state_q <= S_DONE;
				S_DONE: begin
					if (out_free) begin
						count_q       <= cnt_next;
						out_status_q  <= status_q;
						out_id_q      <= 4'(id_q);
						out_tcalls_q  <= own_stop_q[id_q];
						out_ttotal_q  <= own_total_q[id_q];
						out_elapsed_q <= elapsed_q;
						out_edge_q    <= edge_q;
						out_ecalls_q  <= edge_q ? pw_q.stops : '0;
						out_etotal_q  <= edge_q ? pw_q.total : '0;
						out_level_q   <= cnt_next;
						state_q       <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ch.ready        = state_q == S_IDLE;
	assign out_ch.valid       = out_valid_q;
	assign out_ch.status      = out_status_q;
	assign out_ch.echo_id     = out_id_q;
	assign out_ch.timer_calls = out_tcalls_q;
	assign out_ch.timer_total = out_ttotal_q;
	assign out_ch.elapsed     = out_elapsed_q;
	assign out_ch.edge_valid  = out_edge_q;
	assign out_ch.edge_calls  = out_ecalls_q;
	assign out_ch.edge_total  = out_etotal_q;
	assign out_ch.stack_level = out_level_q;

	a_level_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= LVL_BITS'(STACK_DEPTH))
		else $error("stack level beyond depth");

	a_level_step: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> count_q == $past(count_q) || count_q == $past(count_q) + LVL_BITS'(1) ||
			count_q == $past(count_q) - LVL_BITS'(1))
		else $error("stack level moved by more than one");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		stk_req.wr |-> count_q < LVL_BITS'(STACK_DEPTH) && out_free)
		else $error("push into a full stack");

	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_status_q != ST_OK |-> out_elapsed_q == '0 && !out_edge_q)
		else $error("error word carries elapsed time or edge");

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import ncp_pkg::*;

	localparam int CYCLE_LIMIT = 500000;
	localparam int DRAIN_LIMIT = 5000;
	localparam int SETTLE_CYCLES = 20;
	localparam int LONG_STALL = 300;
	localparam logic [TIME_BITS-1:0] TICK_MAX = '1;

	typedef struct packed {
		status_t               status;
		logic [ID_BITS-1:0]    timer;
		logic [COUNT_BITS-1:0] timer_calls;
		logic [TOTAL_BITS-1:0] timer_total;
		logic [TIME_BITS-1:0]  elapsed;
		logic                  edge_valid;
		logic [COUNT_BITS-1:0] edge_calls;
		logic [TOTAL_BITS-1:0] edge_total;
		logic [LVL_BITS-1:0]   level;
	} profile_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	ncp_in_if  in_bus ();
	ncp_out_if out_bus ();

	nested_call_profiler u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_bus),
		.out_ch (out_bus)
	);

	always #5 clk = ~clk;

	// predicted profiler state
	logic [ID_BITS-1:0]    stk_timer [STACK_DEPTH];
	logic [TIME_BITS-1:0]  stk_start [STACK_DEPTH];
	int                    stk_depth;
	logic [COUNT_BITS-1:0] own_starts [NUM_TIMERS];
	logic [COUNT_BITS-1:0] own_stops [NUM_TIMERS];
	logic [TOTAL_BITS-1:0] own_total [NUM_TIMERS];
	logic [COUNT_BITS-1:0] edge_starts [PAIRS];
	logic [COUNT_BITS-1:0] edge_stops [PAIRS];
	logic [TOTAL_BITS-1:0] edge_ticks [PAIRS];

	profile_result_t pending_results [$];
	profile_result_t seen_result;
	profile_result_t want_result;

	logic [TIME_BITS-1:0] clock_now;
	int send_idle_pct;
	int recv_idle_pct;
	int stall_left;
	int cycle_count;
	int error_count;
	int results_checked;
	int n_starts, n_stops, n_full, n_empty, n_mismatch, deepest;

	function automatic profile_result_t tally_event(input logic kind,
			input logic [ID_BITS-1:0] id, input logic [TIME_BITS-1:0] now);
		profile_result_t      r;
		logic [PAIR_BITS-1:0] pidx;
		logic [TIME_BITS-1:0] ticks;
		r = '0;
		r.status = ST_OK;
		r.timer = id;
		if (kind == KIND_START) begin
			n_starts++;
			if (stk_depth >= STACK_DEPTH) begin
				r.status = ST_FULL;
				n_full++;
			end else begin
				own_starts[id] = own_starts[id] + 1'b1;
				if (stk_depth > 0) begin
					pidx = {stk_timer[stk_depth-1], id};
					edge_starts[pidx] = edge_starts[pidx] + 1'b1;
					r.edge_valid = 1'b1;
					r.edge_calls = edge_stops[pidx];
					r.edge_total = edge_ticks[pidx];
				end
				stk_timer[stk_depth] = id;
				stk_start[stk_depth] = now;
				stk_depth++;
			end
		end else begin
			n_stops++;
			if (stk_depth == 0) begin
				r.status = ST_EMPTY;
				n_empty++;
			end else if (stk_timer[stk_depth-1] != id) begin
				r.status = ST_MISMATCH;
				n_mismatch++;
			end else begin
				stk_depth--;
				ticks = now - stk_start[stk_depth];
				r.elapsed = ticks;
				own_stops[id] = own_stops[id] + 1'b1;
				// recursive calls: only the outermost return adds time
				if (own_stops[id] == own_starts[id])
					own_total[id] = own_total[id] + ticks;
				if (stk_depth > 0) begin
					pidx = {stk_timer[stk_depth-1], id};
					edge_stops[pidx] = edge_stops[pidx] + 1'b1;
					if (edge_stops[pidx] == edge_starts[pidx])
						edge_ticks[pidx] = edge_ticks[pidx] + ticks;
					r.edge_valid = 1'b1;
					r.edge_calls = edge_stops[pidx];
					r.edge_total = edge_ticks[pidx];
				end
			end
		end
		r.timer_calls = own_stops[id];
		r.timer_total = own_total[id];
		r.level = LVL_BITS'(stk_depth);
		if (stk_depth > deepest)
			deepest = stk_depth;
		return r;
	endfunction

	function automatic string fmt_result(input profile_result_t r);
		return $sformatf("st=%0d id=%0d calls=%0d total=%0d el=%0d edge=%0b/%0d/%0d lvl=%0d",
			r.status, r.timer, r.timer_calls, r.timer_total, r.elapsed,
			r.edge_valid, r.edge_calls, r.edge_total, r.level);
	endfunction

	function automatic logic [TIME_BITS-1:0] rand_ticks();
		logic [63:0] w;
		w = {$urandom(), $urandom()};
		return w[TIME_BITS-1:0];
	endfunction

	// mostly a forward-running clock, now and then a jump anywhere (elapsed may wrap)
	function automatic logic [TIME_BITS-1:0] next_tick();
		if ($urandom_range(49) == 0)
			clock_now = rand_ticks();
		else
			clock_now = clock_now + TIME_BITS'($urandom_range(1, 5000));
		return clock_now;
	endfunction

	task automatic send_event(input logic kind, input logic [ID_BITS-1:0] id,
			input logic [TIME_BITS-1:0] ts);
		while ($urandom_range(99) < send_idle_pct) begin
			in_bus.valid <= 1'b0;
			@(posedge clk);
		end
		in_bus.valid <= 1'b1;
		in_bus.kind <= kind;
		in_bus.timer_id <= id;
		in_bus.timestamp <= ts;
		@(posedge clk);
		while (in_bus.ready !== 1'b1)
			@(posedge clk);
		pending_results.push_back(tally_event(kind, id, ts));
	endtask

	task automatic random_call_step();
		int                 roll;
		logic [ID_BITS-1:0] pick;
		logic [ID_BITS-1:0] flip;
		roll = $urandom_range(99);
		flip = ID_BITS'($urandom_range(1, 15));
		if (stk_depth > 0 && $urandom_range(3) == 0)
			pick = stk_timer[stk_depth-1];
		else if ($urandom_range(1) == 0)
			pick = ID_BITS'($urandom_range(0, 3));
		else
			pick = ID_BITS'($urandom_range(0, 15));
		if (roll < 4) begin
			send_event(1'($urandom_range(1)), ID_BITS'($urandom_range(15)), rand_ticks());
		end else if (roll < 7) begin
			if (stk_depth > 0)
				send_event(KIND_STOP, stk_timer[stk_depth-1] ^ flip, next_tick());
			else
				send_event(KIND_STOP, pick, next_tick());
		end else if (stk_depth == 0 ||
				(stk_depth < STACK_DEPTH && roll < (stk_depth < 4 ? 62 : 50))) begin
			send_event(KIND_START, pick, next_tick());
		end else begin
			send_event(KIND_STOP, stk_timer[stk_depth-1], next_tick());
		end
	endtask

	task automatic test_directed();
		send_event(KIND_STOP, 4'd5, 48'd100);          // empty stack
		send_event(KIND_START, 4'd0, '0);
		send_event(KIND_START, 4'd15, TICK_MAX);       // first edge 0 -> 15
		send_event(KIND_STOP, 4'd0, 48'd10);           // not on top
		send_event(KIND_STOP, 4'd15, 48'd5);           // elapsed wraps round
		send_event(KIND_START, 4'd7, 48'd20);
		send_event(KIND_START, 4'd7, 48'd30);          // recursive call
		send_event(KIND_STOP, 4'd7, 48'd45);
		send_event(KIND_STOP, 4'd7, 48'd50);           // outer return adds time once
		send_event(KIND_START, 4'd10, 48'd60);
		send_event(KIND_START, 4'd5, 48'd61);
		send_event(KIND_STOP, 4'd5, TICK_MAX);
		send_event(KIND_STOP, 4'd10, '0);
		send_event(KIND_STOP, 4'd0, TICK_MAX);         // largest elapsed
		send_event(KIND_STOP, 4'd0, '0);
		send_event(KIND_START, 4'd15, 48'h5555_5555_5555);
		send_event(KIND_STOP, 4'd15, 48'hAAAA_AAAA_AAAA);
		send_event(KIND_START, 4'd9, 48'h1234_5678_9ABC);
		send_event(KIND_START, 4'd6, 48'hFEDC_BA98_7654);
		send_event(KIND_STOP, 4'd6, 48'hFEDC_BA98_7655);
		send_event(KIND_STOP, 4'd9, 48'h1234_5678_9ABD);
		clock_now = rand_ticks();
	endtask

	task automatic test_random_calls(input int count);
		repeat (count)
			random_call_step();
	endtask

	// push to the limit, push past it, then unwind with the odd bad stop
	task automatic test_deep_stack();
		logic [ID_BITS-1:0] flip;
		while (stk_depth < STACK_DEPTH)
			send_event(KIND_START, ID_BITS'($urandom_range(15)), next_tick());
		repeat (3)
			send_event(KIND_START, ID_BITS'($urandom_range(15)), next_tick());
		while (stk_depth > 0) begin
			flip = ID_BITS'($urandom_range(1, 15));
			if ($urandom_range(7) == 0)
				send_event(KIND_STOP, stk_timer[stk_depth-1] ^ flip, next_tick());
			else
				send_event(KIND_STOP, stk_timer[stk_depth-1], next_tick());
		end
	endtask

	task automatic test_output_stall();
		stall_left = LONG_STALL;
		repeat (25)
			random_call_step();
	endtask

	// result side: random ready, plus the long hold-off when asked
	initial begin
		out_bus.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				out_bus.ready <= 1'b0;
				stall_left--;
			end else begin
				out_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
			seen_result.status = status_t'(out_bus.status);
			seen_result.timer = out_bus.echo_id;
			seen_result.timer_calls = out_bus.timer_calls;
			seen_result.timer_total = out_bus.timer_total;
			seen_result.elapsed = out_bus.elapsed;
			seen_result.edge_valid = out_bus.edge_valid;
			seen_result.edge_calls = out_bus.edge_calls;
			seen_result.edge_total = out_bus.edge_total;
			seen_result.level = out_bus.stack_level;
			results_checked++;
			if (pending_results.size() == 0) begin
				error_count++;
				if (error_count <= 10)
					$display("%0t: unexpected result word %s", $time, fmt_result(seen_result));
			end else begin
				want_result = pending_results.pop_front();
				if (seen_result.status !== want_result.status ||
						seen_result.timer !== want_result.timer ||
						seen_result.timer_calls !== want_result.timer_calls ||
						seen_result.timer_total !== want_result.timer_total ||
						seen_result.elapsed !== want_result.elapsed ||
						seen_result.edge_valid !== want_result.edge_valid ||
						seen_result.edge_calls !== want_result.edge_calls ||
						seen_result.edge_total !== want_result.edge_total ||
						seen_result.level !== want_result.level) begin
					error_count++;
					if (error_count <= 10) begin
						$display("%0t: result mismatch", $time);
						$display("  expected %s", fmt_result(want_result));
						$display("  actual   %s", fmt_result(seen_result));
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, pending_results.size());
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		int drain;
		in_bus.valid <= 1'b0;
		in_bus.kind <= KIND_START;
		in_bus.timer_id <= '0;
		in_bus.timestamp <= '0;
		stk_depth = 0;
		for (int i = 0; i < STACK_DEPTH; i++) begin
			stk_timer[i] = '0;
			stk_start[i] = '0;
		end
		for (int i = 0; i < NUM_TIMERS; i++) begin
			own_starts[i] = '0;
			own_stops[i] = '0;
			own_total[i] = '0;
		end
		for (int i = 0; i < PAIRS; i++) begin
			edge_starts[i] = '0;
			edge_stops[i] = '0;
			edge_ticks[i] = '0;
		end
		clock_now = '0;
		stall_left = 0;
		send_idle_pct = 38;
		recv_idle_pct = 45;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random_calls(430);
		test_deep_stack();
		send_idle_pct = 45;
		recv_idle_pct = 38;
		test_random_calls(430);
		test_output_stall();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_calls(330);
		in_bus.valid <= 1'b0;

		drain = 0;
		while (pending_results.size() != 0 && drain < DRAIN_LIMIT) begin
			@(posedge clk);
			drain++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (pending_results.size() != 0) begin
			$display("%0d expected results never arrived", pending_results.size());
			error_count += pending_results.size();
		end

		$display("Checked %0d results from %0d starts and %0d stops, stack depth up to %0d",
			results_checked, n_starts, n_stops, deepest);
		$display("Error words seen: %0d full stack, %0d empty stack, %0d stop not on top",
			n_full, n_empty, n_mismatch);
		if (error_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule

>>> files.f
rtl/ncp_pkg.sv
rtl/ncp_in_if.sv
rtl/ncp_out_if.sv
rtl/ncp_alu.sv
rtl/ncp_stack.sv
rtl/ncp_pair_ram.sv
rtl/nested_call_profiler.sv
dv/testbench.sv
